// File: rtl/cfd_pkg.sv
// Shared types and constants for the card frame deframer.
package cfd_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = 5;

    // Upper bound on the accepted length byte: the smaller of the largest frame and the buffer.
    localparam int MAX_FRAME_BYTES      = 32;
    localparam logic [5:0] LIMIT_CAP    = 6'((MAX_FRAME_BYTES < BUF_DEPTH) ?
                                             MAX_FRAME_BYTES : BUF_DEPTH);
    localparam logic [4:0] UID_OFFSET   = 5'd4;
    localparam logic [5:0] MIN_LEN      = 6'd5;

    localparam int OUT_TDATA_W = 32;

    // Frame status codes.
    localparam logic [2:0] FS_OK        = 3'd0;
    localparam logic [2:0] FS_BAD_CHK   = 3'd1;
    localparam logic [2:0] FS_OTHER_CMD = 3'd2;
    localparam logic [2:0] FS_ERR_STAT  = 3'd3;
    localparam logic [2:0] FS_SHORT     = 3'd4;
    localparam logic [2:0] FS_UID_OVF   = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYNC_FIRST     = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND    = 3'd1;
    localparam logic [2:0] CFG_CARD_COMMAND   = 3'd2;
    localparam logic [2:0] CFG_SUCCESS_STATUS = 3'd3;
    localparam logic [2:0] CFG_LENGTH_LIMIT   = 3'd4;

    typedef enum logic [2:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_LEN,
        ST_DATA,
        ST_CHECK,
        ST_UID_RD,
        ST_UID_OUT
    } t_state;

    typedef struct packed {
        logic store;
        logic start;
        logic clr_idx;
        logic rd_uid;
        logic emit_single;
        logic emit_uid;
    } t_cmd;

    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic len_ok;
        logic frame_done;
        logic single;
        logic uid_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/cfd_dpath.sv
// Datapath of the card frame deframer: config registers, payload buffer, checks, result register.
module cfd_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_addr,
    input  logic [7:0]                      i_cfg_wdata,
    input  logic [7:0]                      i_rx_byte,
    input  cfd_pkg::t_cmd                   i_cmd,
    output cfd_pkg::t_sts                   o_sts,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cfd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import cfd_pkg::*;

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_card_command;
    logic [7:0] r_success_status;
    logic [5:0] r_length_limit;

    logic [5:0] r_frame_len;
    logic [5:0] r_byte_cnt;
    logic [7:0] r_xor;
    logic [4:0] r_uid_idx;

    logic [7:0] r_buf [BUF_DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_b0, r_b1, r_b2, r_b3;

    logic       r_out_valid;
    logic [2:0] r_st;
    logic [7:0] r_ct;
    logic [4:0] r_ul;
    logic [4:0] r_ui;
    logic [7:0] r_uv;
    logic       r_last;

    logic [5:0] eff_lim;
    logic [8:0] uid_end;
    logic [2:0] frame_status;
    logic [4:0] rd_addr;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first     <= 8'hAA;
            r_sync_second    <= 8'h00;
            r_card_command   <= 8'h01;
            r_success_status <= 8'h00;
            r_length_limit   <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SYNC_FIRST:     r_sync_first     <= i_cfg_wdata;
                CFG_SYNC_SECOND:    r_sync_second    <= i_cfg_wdata;
                CFG_CARD_COMMAND:   r_card_command   <= i_cfg_wdata;
                CFG_SUCCESS_STATUS: r_success_status <= i_cfg_wdata;
                CFG_LENGTH_LIMIT:   r_length_limit   <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign eff_lim = (r_length_limit > LIMIT_CAP) ? LIMIT_CAP : r_length_limit;

    // The running XOR covers every payload byte including the checksum, so a
    // good frame leaves it at zero.
    assign uid_end = {1'b0, r_b3} + 9'(UID_OFFSET);

    always_comb begin
        if (r_xor != 8'd0) begin
            frame_status = FS_BAD_CHK;
        end else if (r_b0 != r_card_command) begin
            frame_status = FS_OTHER_CMD;
        end else if (r_b1 != r_success_status) begin
            frame_status = FS_ERR_STAT;
        end else if (r_frame_len < MIN_LEN) begin
            frame_status = FS_SHORT;
        end else if (uid_end >= {3'b0, r_frame_len}) begin
            frame_status = FS_UID_OVF;
        end else begin
            frame_status = FS_OK;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_sts.sync1_hit  = (i_rx_byte == r_sync_first);
        o_sts.sync2_hit  = (i_rx_byte == r_sync_second);
        o_sts.len_ok     = (i_rx_byte != 8'd0) && (i_rx_byte <= {2'b0, eff_lim});
        o_sts.frame_done = ((r_byte_cnt + 6'd1) == r_frame_len);
        o_sts.single     = (frame_status != FS_OK) || (r_b3 == 8'd0);
        o_sts.uid_last   = (({3'b0, r_uid_idx} + 8'd1) == r_b3);
        o_sts.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= 6'd0;
            r_byte_cnt  <= 6'd0;
            r_xor       <= 8'd0;
            r_uid_idx   <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_frame_len <= i_rx_byte[5:0];
                r_byte_cnt  <= 6'd0;
                r_xor       <= 8'd0;
            end else if (i_cmd.store) begin
                r_byte_cnt <= r_byte_cnt + 6'd1;
                r_xor      <= r_xor ^ i_rx_byte;
            end
            if (i_cmd.clr_idx) begin
                r_uid_idx <= 5'd0;
            end else if (i_cmd.emit_uid) begin
                r_uid_idx <= r_uid_idx + 5'd1;
            end
            if (i_cmd.emit_single || i_cmd.emit_uid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign rd_addr = r_uid_idx + UID_OFFSET;

    // Payload buffer; the header bytes are mirrored in registers for the checks.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_buf[r_byte_cnt[BUF_AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_uid) begin
            r_rd_data <= r_buf[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (r_byte_cnt)
                6'd0:    r_b0 <= i_rx_byte;
                6'd1:    r_b1 <= i_rx_byte;
                6'd2:    r_b2 <= i_rx_byte;
                6'd3:    r_b3 <= i_rx_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_st   <= frame_status;
            r_ct   <= (frame_status == FS_OK) ? r_b2 : 8'd0;
            r_ul   <= 5'd0;
            r_ui   <= 5'd0;
            r_uv   <= 8'd0;
            r_last <= 1'b1;
        end else if (i_cmd.emit_uid) begin
            r_st   <= FS_OK;
            r_ct   <= r_b2;
            r_ul   <= r_b3[4:0];
            r_ui   <= r_uid_idx;
            r_uv   <= r_rd_data;
            r_last <= o_sts.uid_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_uv, r_ui, r_ul, r_ct, r_st};
    assign o_m_tlast  = r_last;

endmodule

// File: rtl/cfd_ctrl.sv
// Controller of the card frame deframer: frame hunt and result sequencing.
module cfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  cfd_pkg::t_sts i_sts,
    output cfd_pkg::t_cmd o_cmd
);
    import cfd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC1;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = r_state inside {ST_SYNC1, ST_SYNC2, ST_LEN, ST_DATA};
    assign acc        = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SYNC1: begin
                if (acc && i_sts.sync1_hit) n_state = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (acc) n_state = i_sts.sync2_hit ? ST_LEN : ST_SYNC1;
            end
            ST_LEN: begin
                if (acc) n_state = i_sts.len_ok ? ST_DATA : ST_SYNC1;
            end
            ST_DATA: begin
                if (acc && i_sts.frame_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!i_sts.single) begin
                    n_state = ST_UID_RD;
                end else if (i_sts.out_free) begin
                    n_state = ST_SYNC1;
                end
            end
            ST_UID_RD: begin
                n_state = ST_UID_OUT;
            end
            ST_UID_OUT: begin
                if (i_sts.out_free) n_state = i_sts.uid_last ? ST_SYNC1 : ST_UID_RD;
            end
            default: n_state = ST_SYNC1;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_LEN:     o_cmd.start       = acc && i_sts.len_ok;
            ST_DATA:    o_cmd.store       = acc;
            ST_CHECK: begin
                o_cmd.clr_idx     = !i_sts.single;
                o_cmd.emit_single = i_sts.single && i_sts.out_free;
            end
            ST_UID_RD:  o_cmd.rd_uid      = 1'b1;
            ST_UID_OUT: o_cmd.emit_uid    = i_sts.out_free;
            default: ;
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_single || o_cmd.emit_uid) |-> i_sts.out_free)
        else $error("result loaded while output register still occupied");

    a_no_input_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK || r_state == ST_UID_RD || r_state == ST_UID_OUT)
        |-> !o_s_tready)
        else $error("input request taken while a frame result is pending");

    a_last_uid_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_uid && i_sts.uid_last) |=> (r_state == ST_SYNC1))
        else $error("last UID byte did not return to sync hunt");

    a_store_excl_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.store && (o_cmd.emit_uid || o_cmd.emit_single)))
        else $error("byte stored while a result is loaded");

endmodule

// File: rtl/card_frame_deframer_xor_unit.sv
// Top level of the card frame deframer with XOR checksum.
// Bytes arrive on the slave stream. The block hunts for the two sync bytes and a
// length byte (zero, or above length_limit capped at 32, restarts the hunt), stores
// the payload and, on its last byte, checks the XOR checksum, command, status,
// minimum length of five and UID length in that order. The slave tready stays high
// through the hunt and the payload. After the last payload byte the input stalls
// while the checks run; then a rejected frame or an empty UID gives one result, and
// a good frame gives one result per UID byte, each fetched by a registered read of
// the payload buffer before it is loaded; results wait while the master holds tready low.
// Results carry tlast on the final one of each frame.
module card_frame_deframer_xor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] frame_status, [10:3] card_kind, [15:11] uid_length,
    // [20:16] uid_index, [28:21] uid_value, [31:29] zero
    output logic [cfd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast    // last_of_run
);
    import cfd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cfd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_byte   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule
